// File: rtl/bss_pkg.sv
// Package: shared constants, opcodes and controller/datapath command types.
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

  // Default buffer depth
  localparam int SIZE_DEF = 16;

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int TOTAL_W  = 20;
  localparam int MEAN_W   = 16;

  // Opcodes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // latch input beat, update count and total
    logic div_start;  // launch mean division
    logic ins_step;   // one step of sorted insertion
    logic med_rd_hi;  // read upper middle entry
    logic med_rd_lo;  // capture upper middle, read lower middle
    logic med_lat_a;  // capture lower middle
    logic out_load;   // load result register
  } bss_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic do_ins;     // current beat stores a sample
    logic ins_done;   // insertion slot found this cycle
    logic cnt_zero;   // buffer is empty
    logic div_busy;   // divider still iterating
    logic out_full;   // result register holds a beat not taken this cycle
  } bss_stat_t;

endpackage

`default_nettype wire

// File: rtl/bss_in_if.sv
// Interface: input channel carrying opcode and sample.
`timescale 1ns / 1ps
`default_nettype none

interface bss_in_if import bss_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output opcode, output sample, input ready);
  modport sink   (input valid, input opcode, input sample, output ready);
endinterface

`default_nettype wire

// File: rtl/bss_out_if.sv
// Interface: result channel carrying the buffer statistics.
`timescale 1ns / 1ps
`default_nettype none

interface bss_out_if import bss_pkg::*; #(
  parameter int CNT_W = $clog2(SIZE_DEF + 1)
);
  logic                       valid;
  logic                       ready;
  logic                       accepted;
  logic [CNT_W-1:0]           count;
  logic signed [TOTAL_W-1:0]  total;
  logic signed [MEAN_W-1:0]   mean;
  logic signed [SAMPLE_W-1:0] middle;

  modport source (output valid, output accepted, output count, output total,
                  output mean, output middle, input ready);
  modport sink   (input valid, input accepted, input count, input total,
                  input mean, input middle, output ready);
endinterface

`default_nettype wire

// File: rtl/bounded_sample_stats_buffer.sv
// Top level: bounded sample buffer reporting count, total, mean and median per beat.
//
//  Channel   Role   Beat payload
//  samples   sink   opcode, sample
//  stats     source accepted, count, total, mean, middle
//
// One beat is processed at a time; the result loads once the one-bit-per-cycle mean divider
// has finished and the median entries are read, after any sorted insertion that walks the
// memory one entry a cycle; a flush skips the divider, the insertion and the median reads.
// Ready returns the cycle after the result loads.
// Reset clears count, total and the result valid; sample memory is not cleared.
// A waiting result does not block the next beat; a result stalls only if the
// previous one is still not taken when it is finished.
`timescale 1ns / 1ps
`default_nettype none

module bounded_sample_stats_buffer import bss_pkg::*; #(
  parameter int SIZE = SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bss_in_if.sink    samples,
  bss_out_if.source stats
);

  bss_cmd_t  cmd;
  bss_stat_t stat;

  bss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bss_datapath #(
    .SIZE (SIZE)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_opcode    (samples.opcode),
    .in_sample    (samples.sample),
    .out_valid    (stats.valid),
    .out_ready    (stats.ready),
    .out_accepted (stats.accepted),
    .out_count    (stats.count),
    .out_total    (stats.total),
    .out_mean     (stats.mean),
    .out_middle   (stats.middle)
  );

endmodule

`default_nettype wire

// File: rtl/bss_div.sv
// Module: restoring divider, signed dividend by unsigned divisor, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module bss_div import bss_pkg::*; #(
  parameter int NUM_W = TOTAL_W,
  parameter int DEN_W = $clog2(SIZE_DEF + 1),
  localparam int STEP_W = $clog2(NUM_W + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    busy,
  output logic [NUM_W-1:0]        quo
);

  logic [STEP_W-1:0] steps;
  logic [DEN_W-1:0]  rem;
  logic [NUM_W-1:0]  acc;
  logic [DEN_W-1:0]  den_q;
  logic              neg;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  // Shift in next dividend bit and try subtracting
  always_comb begin
    trial = {rem, acc[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
  end

  // Control: iteration count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(NUM_W);
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: magnitude, remainder and quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= num[NUM_W-1];
      acc   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      acc <= {acc[NUM_W-2:0], ge};
    end
  end

  // Apply sign, truncation toward zero
  assign quo = neg ? NUM_W'(-acc) : acc;

endmodule

`default_nettype wire

// File: rtl/bss_datapath.sv
// Module: count and total registers, sorted sample memory, median and result register.
`timescale 1ns / 1ps
`default_nettype none

module bss_datapath import bss_pkg::*; #(
  parameter int SIZE = SIZE_DEF,
  localparam int CNT_W = $clog2(SIZE + 1),
  localparam int IDX_W = (SIZE > 1) ? $clog2(SIZE) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bss_cmd_t                   cmd,
  output bss_stat_t                  stat,
  input  logic                       in_opcode,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_accepted,
  output logic [CNT_W-1:0]           out_count,
  output logic signed [TOTAL_W-1:0]  out_total,
  output logic signed [MEAN_W-1:0]   out_mean,
  output logic signed [SAMPLE_W-1:0] out_middle
);

  logic [CNT_W-1:0]           held_count;
  logic signed [TOTAL_W-1:0]  running_total;
  logic                       do_ins;
  logic                       ok_flag;
  logic signed [SAMPLE_W-1:0] samp;
  logic [CNT_W-1:0]           ins_pos;
  logic signed [SAMPLE_W-1:0] sorted_mem [SIZE];
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W-1:0] med_a;
  logic signed [SAMPLE_W-1:0] med_b;

  logic signed [TOTAL_W-1:0]  sample_ext;
  logic                       shift;
  logic [CNT_W-1:0]           half;
  logic [CNT_W-1:0]           rd_ptr;
  logic [IDX_W-1:0]           rd_addr;
  logic [IDX_W-1:0]           wr_addr;
  logic                       div_busy;
  logic [TOTAL_W-1:0]         quo;
  logic signed [SAMPLE_W:0]   pair_sum;
  logic signed [SAMPLE_W:0]   pair_adj;
  logic signed [SAMPLE_W:0]   pair_half;
  logic signed [SAMPLE_W-1:0] mid;

  assign sample_ext = {{(TOTAL_W - SAMPLE_W){in_sample[SAMPLE_W-1]}}, in_sample};

  // Count, total and insert flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= '0;
      running_total <= '0;
      do_ins        <= 1'b0;
    end else if (cmd.load) begin
      do_ins <= 1'b0;
      if (in_opcode == OP_FLUSH) begin
        held_count    <= '0;
        running_total <= '0;
      end else if (held_count < CNT_W'(SIZE)) begin
        do_ins        <= 1'b1;
        held_count    <= held_count + 1'b1;
        running_total <= running_total + sample_ext;
      end
    end
  end

  // Beat payload: sample, accept flag, insertion position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      samp    <= in_sample;
      ins_pos <= held_count;
      ok_flag <= (in_opcode == OP_FLUSH) || (held_count < CNT_W'(SIZE));
    end else if (cmd.ins_step && shift) begin
      ins_pos <= ins_pos - 1'b1;
    end
  end

  // Move the entry below up while the new sample is not above it
  assign shift = (ins_pos != '0) && (samp <= rd_data);
  assign half  = held_count >> 1;

  // Select read address for the single read port
  always_comb begin
    priority if (cmd.med_rd_hi) begin
      rd_ptr = half;
    end else if (cmd.med_rd_lo) begin
      rd_ptr = half - 1'b1;
    end else if (cmd.ins_step && shift) begin
      rd_ptr = ins_pos - 1'b1 - 1'b1;
    end else begin
      rd_ptr = ins_pos - 1'b1;
    end
  end

  assign rd_addr = rd_ptr[IDX_W-1:0];
  assign wr_addr = ins_pos[IDX_W-1:0];

  // Sorted memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.ins_step) begin
      sorted_mem[wr_addr] <= shift ? rd_data : samp;
    end
    rd_data <= sorted_mem[rd_addr];
  end

  // Capture middle entries
  always_ff @(posedge clk) begin
    if (cmd.med_rd_lo) begin
      med_b <= rd_data;
    end
    if (cmd.med_lat_a) begin
      med_a <= rd_data;
    end
  end

  // Mean divider
  bss_div #(
    .NUM_W (TOTAL_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (running_total),
    .den   (held_count),
    .busy  (div_busy),
    .quo   (quo)
  );

  // Median: odd count takes the middle, even count halves the pair toward zero
  always_comb begin
    pair_sum  = {med_a[SAMPLE_W-1], med_a} + {med_b[SAMPLE_W-1], med_b};
    pair_adj  = pair_sum + {{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]};
    pair_half = pair_adj >>> 1;
    mid       = held_count[0] ? med_b : pair_half[SAMPLE_W-1:0];
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_accepted <= ok_flag;
      out_count    <= held_count;
      out_total    <= running_total;
      out_mean     <= stat.cnt_zero ? '0 : quo[MEAN_W-1:0];
      out_middle   <= stat.cnt_zero ? '0 : mid;
    end
  end

  // Status to controller
  always_comb begin
    stat.do_ins   = do_ins;
    stat.ins_done = !shift;
    stat.cnt_zero = (held_count == '0);
    stat.div_busy = div_busy;
    stat.out_full = out_valid && !out_ready;
  end

endmodule

`default_nettype wire

// File: rtl/bss_ctrl.sv
// Module: controller state machine sequencing load, insertion, median reads and result.
`timescale 1ns / 1ps
`default_nettype none

module bss_ctrl import bss_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  bss_stat_t stat,
  output bss_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PREP = 7'b0000010,
    S_INS  = 7'b0000100,
    S_MED1 = 7'b0001000,
    S_MED2 = 7'b0010000,
    S_MED3 = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.div_start = !stat.cnt_zero;
        if (stat.do_ins) begin
          state_next = S_INS;
        end else if (stat.cnt_zero) begin
          state_next = S_FIN;
        end else begin
          state_next = S_MED1;
        end
      end
      S_INS: begin
        cmd.ins_step = 1'b1;
        if (stat.ins_done) begin
          state_next = S_MED1;
        end
      end
      S_MED1: begin
        cmd.med_rd_hi = 1'b1;
        state_next    = S_MED2;
      end
      S_MED2: begin
        cmd.med_rd_lo = 1'b1;
        state_next    = S_MED3;
      end
      S_MED3: begin
        cmd.med_lat_a = 1'b1;
        state_next    = S_FIN;
      end
      S_FIN: begin
        // Hold until the divider ends and the result slot is free
        if (!stat.div_busy && !stat.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

endmodule

`default_nettype wire

// File: rtl/bss_checker.sv
// Checker: port-level assertions on the buffer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bss_checker import bss_pkg::*; #(
  parameter int SIZE = SIZE_DEF,
  localparam int CNT_W = $clog2(SIZE + 1)
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_accepted,
  input logic [CNT_W-1:0]           out_count,
  input logic signed [TOTAL_W-1:0]  out_total,
  input logic signed [MEAN_W-1:0]   out_mean,
  input logic signed [SAMPLE_W-1:0] out_middle
);

  // One beat in flight: ready drops after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a beat is in progress");

  // Count never exceeds depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_count <= SIZE)
    else $error("count above buffer depth");

  // Refusal only when full
  a_refuse_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_accepted |-> out_count == CNT_W'(SIZE))
    else $error("add refused while buffer not full");

  // Empty buffer reports zero statistics
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_count == '0 |-> out_total == '0 && out_mean == '0 &&
    out_middle == '0)
    else $error("empty buffer with nonzero statistics");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_accepted) &&
    $stable(out_count) && $stable(out_total) && $stable(out_mean) &&
    $stable(out_middle))
    else $error("stalled result changed");

endmodule

bind bounded_sample_stats_buffer bss_checker #(
  .SIZE (SIZE)
) u_bss_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (samples.valid),
  .in_ready     (samples.ready),
  .out_valid    (stats.valid),
  .out_ready    (stats.ready),
  .out_accepted (stats.accepted),
  .out_count    (stats.count),
  .out_total    (stats.total),
  .out_mean     (stats.mean),
  .out_middle   (stats.middle)
);

`default_nettype wire

// File: tb/tb_top.sv
// Testbench: directed and random beats into the sample statistics buffer, checked per result.
`timescale 1ns / 1ps

module tb_top;
  import bss_pkg::*;

  localparam int CNT_W        = $clog2(SIZE_DEF + 1);
  localparam int RANDOM_BEATS = 700;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 50;

  typedef struct packed {
    logic                       accepted;
    logic [CNT_W-1:0]           count;
    logic signed [TOTAL_W-1:0]  total;
    logic signed [MEAN_W-1:0]   mean;
    logic signed [SAMPLE_W-1:0] middle;
  } stats_t;

  typedef struct {
    logic                       op;
    logic signed [SAMPLE_W-1:0] smp;
    bit                         typed;
    stats_t                     want;
  } dir_row_t;

  typedef enum int {FILL_ANY, FILL_NEAR_ZERO, FILL_EDGES, FILL_PINNED} fill_kind_e;
  typedef enum int {TAKE_ALL, TAKE_COIN, TAKE_NONE} take_kind_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic take_stats = 1'b0;

  bss_in_if  samples_ch ();
  bss_out_if stats_ch ();

  assign stats_ch.ready = take_stats;

  bounded_sample_stats_buffer #(.SIZE(SIZE_DEF)) dut (
    .clk    (clk),
    .rst    (rst),
    .samples(samples_ch),
    .stats  (stats_ch)
  );

  always #5 clk = ~clk;

  // Predictor state: sorted copy of held samples, count and wrapping sum
  logic signed [SAMPLE_W-1:0] sorted_vals [SIZE_DEF];
  int                         held_n  = 0;
  logic signed [TOTAL_W-1:0]  sum_acc = '0;

  stats_t pending_stats [$];
  int     errors       = 0;
  int     cycle_count  = 0;
  int     burst_left   = 1;
  bit     feeding      = 1'b0;

  // Directed beats; typed rows carry an expected result read straight off the spec
  dir_row_t dir_rows [25] = '{
    '{OP_ADD,   16'sh8000, 1'b1, '{1'b1, 5'd1, -20'sd32768, 16'sh8000, 16'sh8000}},
    '{OP_FLUSH, 16'sd0,    1'b1, '{1'b1, 5'd0, 20'sd0, 16'sd0, 16'sd0}},
    '{OP_FLUSH, 16'sh7fff, 1'b1, '{1'b1, 5'd0, 20'sd0, 16'sd0, 16'sd0}},
    '{OP_ADD,   16'sh7fff, 1'b1, '{1'b1, 5'd1, 20'sd32767, 16'sh7fff, 16'sh7fff}},
    '{OP_ADD,   16'sh7fff, 1'b1, '{1'b1, 5'd2, 20'sd65534, 16'sh7fff, 16'sh7fff}},
    '{OP_ADD,   -16'sd1,   1'b0, '0},
    '{OP_ADD,   16'sd0,    1'b0, '0},
    '{OP_ADD,   16'sd1,    1'b0, '0},
    '{OP_ADD,   16'sh8000, 1'b0, '0},
    '{OP_ADD,   16'sd5,    1'b0, '0},
    '{OP_ADD,   16'sd5,    1'b0, '0},
    '{OP_ADD,   -16'sd7,   1'b0, '0},
    '{OP_ADD,   16'sd100,  1'b0, '0},
    '{OP_ADD,   -16'sd100, 1'b0, '0},
    '{OP_ADD,   16'sh7fff, 1'b0, '0},
    '{OP_ADD,   16'sh8000, 1'b0, '0},
    '{OP_ADD,   16'sd3,    1'b0, '0},
    '{OP_ADD,   -16'sd3,   1'b0, '0},
    '{OP_ADD,   16'sd9,    1'b0, '0},
    '{OP_ADD,   16'sd1234, 1'b0, '0},
    '{OP_ADD,   -16'sd1,   1'b0, '0},
    '{OP_FLUSH, 16'sh5a5a, 1'b1, '{1'b1, 5'd0, 20'sd0, 16'sd0, 16'sd0}},
    '{OP_ADD,   -16'sd1,   1'b1, '{1'b1, 5'd1, -20'sd1, -16'sd1, -16'sd1}},
    '{OP_ADD,   16'sd0,    1'b1, '{1'b1, 5'd2, -20'sd1, 16'sd0, 16'sd0}},
    '{OP_FLUSH, -16'sd1,   1'b1, '{1'b1, 5'd0, 20'sd0, 16'sd0, 16'sd0}}
  };

  // Apply one beat to the predicted buffer and return the statistics it reports
  function automatic stats_t apply_to_buffer(input logic op,
                                             input logic signed [SAMPLE_W-1:0] s);
    stats_t r;
    int     j;
    int     h;
    int     t;
    r          = '0;
    r.accepted = 1'b1;
    if (op == OP_FLUSH) begin
      held_n  = 0;
      sum_acc = '0;
    end else if (held_n >= SIZE_DEF) begin
      r.accepted = 1'b0;
    end else begin
      // shift larger-or-equal entries up to open the slot
      j = held_n;
      while (j > 0 && s <= sorted_vals[j-1]) begin
        sorted_vals[j] = sorted_vals[j-1];
        j--;
      end
      sorted_vals[j] = s;
      held_n++;
      sum_acc = sum_acc + s;
    end
    r.count = CNT_W'(held_n);
    r.total = sum_acc;
    if (held_n > 0) begin
      t      = sum_acc;
      r.mean = MEAN_W'(t / held_n);
      h      = held_n / 2;
      if (held_n % 2 == 0) begin
        r.middle = SAMPLE_W'((int'(sorted_vals[h-1]) + int'(sorted_vals[h])) / 2);
      end else begin
        r.middle = sorted_vals[h];
      end
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input fill_kind_e kind,
                                                             input logic signed [SAMPLE_W-1:0] pinned);
    case (kind)
      FILL_ANY:       return SAMPLE_W'($urandom);
      FILL_NEAR_ZERO: return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
      FILL_EDGES: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return -16'sd1;
          3:       return 16'sd0;
          default: return 16'sd1;
        endcase
      end
      default:        return pinned;
    endcase
  endfunction

  // Drop valid and hold until every predicted result has been taken
  task automatic hold_until_drained();
    if (feeding) begin
      samples_ch.valid <= 1'b0;
      feeding = 1'b0;
    end
    while (pending_stats.size() != 0) @(posedge clk);
  endtask

  // Drive one beat, record its expected result on accept, then pace the burst
  task automatic send_beat(input logic op, input logic signed [SAMPLE_W-1:0] s,
                           input bit typed, input stats_t want);
    stats_t predicted;
    int     gap;
    samples_ch.valid  <= 1'b1;
    samples_ch.opcode <= op;
    samples_ch.sample <= s;
    feeding = 1'b1;
    do @(posedge clk); while (!samples_ch.ready);
    predicted = apply_to_buffer(op, s);
    pending_stats.push_back(typed ? want : predicted);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap        = $urandom_range(1, 30);
      samples_ch.valid <= 1'b0;
      feeding = 1'b0;
      repeat (gap) @(posedge clk);
      if ($urandom_range(0, 11) == 0) hold_until_drained();
    end
  endtask

  // Stall the result channel in segments: open, coin flip, or closed
  take_kind_e take_kind = TAKE_ALL;
  int         take_left = 0;

  always @(posedge clk) begin
    if (take_left == 0) begin
      take_kind = take_kind_e'($urandom_range(0, 2));
      take_left = $urandom_range(1, 40);
    end
    take_left--;
    case (take_kind)
      TAKE_ALL:  take_stats <= 1'b1;
      TAKE_COIN: take_stats <= 1'($urandom_range(0, 1));
      default:   take_stats <= 1'b0;
    endcase
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    stats_t want;
    if (!rst && stats_ch.valid && stats_ch.ready) begin
      if (pending_stats.size() == 0) begin
        $error("result beat with no expectation pending");
        errors++;
      end else begin
        want = pending_stats.pop_front();
        if (stats_ch.accepted !== want.accepted) begin
          $error("accepted mismatch: expected %0d, actual %0d", want.accepted, stats_ch.accepted);
          errors++;
        end
        if (stats_ch.count !== want.count) begin
          $error("count mismatch: expected %0d, actual %0d", want.count, stats_ch.count);
          errors++;
        end
        if (stats_ch.total !== want.total) begin
          $error("total mismatch: expected %0d, actual %0d",
                 $signed(want.total), $signed(stats_ch.total));
          errors++;
        end
        if (stats_ch.mean !== want.mean) begin
          $error("mean mismatch: expected %0d, actual %0d",
                 $signed(want.mean), $signed(stats_ch.mean));
          errors++;
        end
        if (stats_ch.middle !== want.middle) begin
          $error("middle mismatch: expected %0d, actual %0d",
                 $signed(want.middle), $signed(stats_ch.middle));
          errors++;
        end
      end
    end
  end

  // Count cycles and bail out on a hung run
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int             sent;
    int             fill_len;
    fill_kind_e     kind;
    logic signed [SAMPLE_W-1:0] pinned;
    sent = 0;
    samples_ch.valid  <= 1'b0;
    samples_ch.opcode <= OP_ADD;
    samples_ch.sample <= '0;
    rst               <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].op, dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
    end
    hold_until_drained();

    // Random fills with random content, some overfilled, most ended by a flush
    while (sent < RANDOM_BEATS) begin
      kind     = fill_kind_e'($urandom_range(0, 3));
      pinned   = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      fill_len = ($urandom_range(0, 4) == 0) ? $urandom_range(SIZE_DEF, SIZE_DEF + 4)
                                             : $urandom_range(1, SIZE_DEF);
      repeat (fill_len) begin
        send_beat(OP_ADD, pick_sample(kind, pinned), 1'b0, '0);
        sent++;
      end
      if ($urandom_range(0, 5) != 0) begin
        send_beat(OP_FLUSH, SAMPLE_W'($urandom), 1'b0, '0);
        sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_beat(OP_FLUSH, SAMPLE_W'($urandom), 1'b0, '0);
        sent++;
      end
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/bss_pkg.sv
rtl/bss_in_if.sv
rtl/bss_out_if.sv
rtl/bss_div.sv
rtl/bss_datapath.sv
rtl/bss_ctrl.sv
rtl/bounded_sample_stats_buffer.sv
rtl/bss_checker.sv
tb/tb_top.sv
